// ===== rtl/vowel_cluster_syllable_splitter_defines.svh =====
// ----------------------------------------------------------------------------
// vowel_cluster_syllable_splitter_defines
// Assertion macros shared by the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef VOWEL_CLUSTER_SYLLABLE_SPLITTER_DEFINES_SVH
`define VOWEL_CLUSTER_SYLLABLE_SPLITTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VCSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcss: implication check failed");

// next-cycle implication, checked outside reset
`define VCSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcss: next-cycle check failed");

`endif

// ===== rtl/vcss_pkg.sv =====
// ----------------------------------------------------------------------------
// vcss_pkg
// Types, constants and character-class functions of the syllable splitter.
// ----------------------------------------------------------------------------
package vcss_pkg;

    localparam int MAX_WORD_LEN  = 64;
    localparam int MAX_SYLLABLES = 32;

    localparam int CHAR_W = 8;
    localparam int SYL_W  = 6;
    localparam int POS_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int RUN_W  = 3;
    localparam int CFG_AW = 2;

    localparam logic [CHAR_W-1:0] HYPHEN   = 8'd45;
    localparam logic [CHAR_W-1:0] SENTINEL = 8'd35;
    localparam logic [CHAR_W-1:0] CH_A = 8'd97;
    localparam logic [CHAR_W-1:0] CH_E = 8'd101;
    localparam logic [CHAR_W-1:0] CH_I = 8'd105;
    localparam logic [CHAR_W-1:0] CH_O = 8'd111;
    localparam logic [CHAR_W-1:0] CH_U = 8'd117;
    localparam logic [CHAR_W-1:0] CH_Y = 8'd121;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_EXTRA_A = 2'd0;
    localparam logic [CFG_AW-1:0] REG_EXTRA_B = 2'd1;
    localparam logic [CFG_AW-1:0] REG_EXTRA_C = 2'd2;
    localparam logic [CFG_AW-1:0] REG_UUMLAUT = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] extra_a;
        logic [CHAR_W-1:0] extra_b;
        logic [CHAR_W-1:0] extra_c;
        logic [CHAR_W-1:0] u_umlaut;
    } cfg_t;

    // one emitted byte with its optional leading hyphen
    typedef struct packed {
        logic              hyph;
        logic [CHAR_W-1:0] chr;
        logic              last;
        logic [SYL_W-1:0]  count;
        logic              err;
    } slot_t;

    // word phases: plain byte, sentinel step, final flush
    typedef enum logic [1:0] {
        PH_CHAR,
        PH_SENT,
        PH_FINAL
    } phase_t;

    function automatic logic is_vowel(input logic [CHAR_W-1:0] c, input cfg_t cfg);
        logic base;
        logic extra;
        base  = (c == CH_A) || (c == CH_E) || (c == CH_I) ||
                (c == CH_O) || (c == CH_U) || (c == CH_Y);
        extra = (c == cfg.extra_a) || (c == cfg.extra_b) ||
                (c == cfg.extra_c) || (c == cfg.u_umlaut);
        return (c != '0) && (base || extra);
    endfunction

    function automatic logic is_falling(input logic [CHAR_W-1:0] first,
                                        input logic [CHAR_W-1:0] second,
                                        input cfg_t cfg);
        logic res;
        if (first == CH_I) begin
            res = (second == CH_A) || (second == CH_E) ||
                  (second == CH_O) || (second == CH_U);
        end else if (first == CH_E) begin
            res = (second == CH_A) || (second == CH_O);
        end else if (first == CH_U) begin
            res = (second == CH_A) || (second == CH_E) || (second == CH_O);
        end else if ((cfg.u_umlaut != '0) && (first == cfg.u_umlaut)) begin
            res = (second == CH_A) || (second == CH_O);
        end else begin
            res = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== rtl/vowel_cluster_syllable_splitter.sv =====
// ----------------------------------------------------------------------------
// vowel_cluster_syllable_splitter
// Inserts hyphens at syllable limits of a streamed lower-case word.
// ----------------------------------------------------------------------------
// Bytes of one word enter one byte per cycle while s_tready is high, s_tlast on
// the last byte, and leave two bytes late with hyphen words (45) put in before
// the bytes that open a new syllable; the single result register sends one
// word per cycle while m_tready is high, the hyphen word before its byte. The
// end of a word adds two steps (a virtual '#' sentinel and the flush of the
// last byte), so the closing byte holds the input until both steps and any
// hyphen words are done. The last result word carries the syllable count and
// an error flag for words that are too long or have too many syllables; after
// an error no more hyphens are inserted. The user must set the extra vowel and
// u-umlaut codes through the cfg_wr port while no word is in flight; not enforced.
// ----------------------------------------------------------------------------
module vowel_cluster_syllable_splitter
    import vcss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] in_char
    input  logic              s_tlast,    // word_end
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,    // [7:0] out_char, [13:8] syllable_count,
                                          // [14] word_error, [15] zero
    output logic              m_tlast,    // out_last
    // configuration writes
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_wr_addr,
    input  logic [CHAR_W-1:0] cfg_wr_data
);

    cfg_t  cfg_reg, cfg_next;
    slot_t slot;
    logic  slot_load, slot_free;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                REG_EXTRA_A: cfg_next.extra_a  = cfg_wr_data;
                REG_EXTRA_B: cfg_next.extra_b  = cfg_wr_data;
                REG_EXTRA_C: cfg_next.extra_c  = cfg_wr_data;
                REG_UUMLAUT: cfg_next.u_umlaut = cfg_wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vcss_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_end    (s_tlast),
        .cfg       (cfg_reg),
        .slot_free (slot_free),
        .slot_load (slot_load),
        .slot      (slot)
    );

    vcss_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .slot_load (slot_load),
        .slot      (slot),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/vcss_core.sv =====
// ----------------------------------------------------------------------------
// vcss_core
// Input register, per-word state and the split rules; one step per cycle while the result slot is free.
// ----------------------------------------------------------------------------
`include "vowel_cluster_syllable_splitter_defines.svh"

module vcss_core
    import vcss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_end,
    input  cfg_t              cfg,
    input  logic              slot_free,
    output logic              slot_load,
    output slot_t             slot
);

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;
    logic              in_end_reg, in_end_next;
    phase_t            phase_reg, phase_next;

    logic [CHAR_W-1:0] d0_reg, d0_next, d1_reg, d1_next;
    logic              hp0_reg, hp0_next, hp1_reg, hp1_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [SYL_W-1:0]  syl_reg, syl_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              err_reg, err_next;

    // step results
    logic [CHAR_W-1:0] step_char;
    logic              emit, advance, consume;
    logic [POS_W-1:0]  pos_step;
    logic              err0, vowel, split, split_k1, first_syl, inc;
    logic [SYL_W-1:0]  syl_step;
    logic              err_step, hp0_step, hp1_step;

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            unique case (phase_reg)
                PH_CHAR:  phase_next = in_end_reg ? PH_SENT : PH_CHAR;
                PH_SENT:  phase_next = PH_FINAL;
                PH_FINAL: phase_next = PH_CHAR;
                default:  phase_next = PH_CHAR;
            endcase
        end
    end

    // phase-dependent controls
    always_comb begin
        unique case (phase_reg)
            PH_CHAR: begin
                step_char = in_char_reg;
                emit      = (pos_reg >= POS_W'(2));
                consume   = advance && !in_end_reg;
            end
            PH_SENT: begin
                step_char = SENTINEL;
                emit      = (pos_reg >= POS_W'(2));
                consume   = 1'b0;
            end
            PH_FINAL: begin
                step_char = SENTINEL;
                emit      = 1'b1;
                consume   = advance;
            end
            default: begin
                step_char = in_char_reg;
                emit      = 1'b0;
                consume   = 1'b0;
            end
        endcase
    end

    assign advance   = in_valid_reg && (!emit || slot_free);
    assign in_ready  = !in_valid_reg || consume;
    assign slot_load = advance && emit;

    // split rules for the current byte
    always_comb begin
        pos_step = pos_reg;
        if ((phase_reg == PH_CHAR) && (pos_reg < POS_W'(MAX_WORD_LEN))) begin
            pos_step = pos_reg + POS_W'(1);
        end
        err0      = err_reg || (pos_step >= POS_W'(MAX_WORD_LEN));
        vowel     = is_vowel(step_char, cfg);
        first_syl = vowel && (run_reg == '0) && (syl_reg == '0);
        if (vowel) begin
            split    = (run_reg == '0) && (syl_reg != '0);
            split_k1 = 1'b0;
        end else begin
            split    = (run_reg == RUN_W'(3)) ||
                       ((run_reg == RUN_W'(2)) && (syl_reg > SYL_W'(1)) &&
                        is_falling(d1_reg, d0_reg, cfg));
            split_k1 = (run_reg == RUN_W'(3)) && (d0_reg == d1_reg);
        end
        inc      = (split || first_syl) && !err0;
        syl_step = syl_reg + SYL_W'(inc);
        err_step = err0 || (inc && (syl_step >= SYL_W'(MAX_SYLLABLES)));
        hp0_step = hp0_reg || (inc && split && !split_k1);
        hp1_step = hp1_reg || (inc && split && split_k1);
    end

    // slot handed to the output stage
    always_comb begin
        slot.chr = d1_reg;
        if (phase_reg == PH_FINAL) begin
            slot.hyph  = hp1_reg;
            slot.last  = 1'b1;
            slot.count = syl_reg;
            slot.err   = err_reg;
        end else begin
            slot.hyph  = hp1_step;
            slot.last  = 1'b0;
            slot.count = '0;
            slot.err   = 1'b0;
        end
    end

    // state update
    always_comb begin
        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        in_end_next   = in_end_reg;
        d0_next  = d0_reg;
        d1_next  = d1_reg;
        hp0_next = hp0_reg;
        hp1_next = hp1_reg;
        run_next = run_reg;
        syl_next = syl_reg;
        pos_next = pos_reg;
        err_next = err_reg;
        if (in_ready) begin
            in_valid_next = in_valid;
            in_char_next  = in_char;
            in_end_next   = in_end;
        end
        if (advance) begin
            if (phase_reg == PH_FINAL) begin
                d0_next  = '0;
                d1_next  = '0;
                hp0_next = 1'b0;
                hp1_next = 1'b0;
                run_next = '0;
                syl_next = '0;
                pos_next = '0;
                err_next = 1'b0;
            end else begin
                d1_next  = d0_reg;
                hp1_next = hp0_step;
                d0_next  = step_char;
                hp0_next = 1'b0;
                if (vowel) begin
                    run_next = (run_reg == '1) ? run_reg : run_reg + RUN_W'(1);
                end else begin
                    run_next = '0;
                end
                syl_next = syl_step;
                pos_next = pos_step;
                err_next = err_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_CHAR;
            d0_reg  <= '0;
            d1_reg  <= '0;
            hp0_reg <= 1'b0;
            hp1_reg <= 1'b0;
            run_reg <= '0;
            syl_reg <= '0;
            pos_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            d0_reg  <= d0_next;
            d1_reg  <= d1_next;
            hp0_reg <= hp0_next;
            hp1_reg <= hp1_next;
            run_reg <= run_next;
            syl_reg <= syl_next;
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        in_char_reg <= in_char_next;
        in_end_reg  <= in_end_next;
    end

    // end-of-word steps only run while the closing word is held
    `VCSS_ASSERT_IMP(a_flush_holds_item, aclk, aresetn, phase_reg != PH_CHAR, in_valid_reg)
    // counts stay in range
    `VCSS_ASSERT_IMP(a_syl_bound, aclk, aresetn, 1'b1, syl_reg <= SYL_W'(MAX_SYLLABLES))
    `VCSS_ASSERT_IMP(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= POS_W'(MAX_WORD_LEN))

endmodule

// ===== rtl/vcss_out.sv =====
// ----------------------------------------------------------------------------
// vcss_out
// Result register: sends an optional hyphen word, then the byte word.
// ----------------------------------------------------------------------------
`include "vowel_cluster_syllable_splitter_defines.svh"

module vcss_out
    import vcss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        slot_load,
    input  slot_t       slot,
    output logic        slot_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic  valid_reg, valid_next;
    logic  hyph_reg, hyph_next;
    slot_t slot_reg, slot_next;
    logic  last_word;

    // the slot frees when its byte word leaves
    assign slot_free = !valid_reg || (m_tready && !hyph_reg);
    assign last_word = slot_reg.last && !hyph_reg;

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_word;
    assign m_tdata  = {1'b0,
                       last_word && slot_reg.err,
                       last_word ? slot_reg.count : SYL_W'(0),
                       hyph_reg ? HYPHEN : slot_reg.chr};

    always_comb begin
        valid_next = valid_reg;
        hyph_next  = hyph_reg;
        slot_next  = slot_reg;
        if (valid_reg && m_tready) begin
            if (hyph_reg) begin
                hyph_next = 1'b0;
            end else begin
                valid_next = 1'b0;
            end
        end
        if (slot_load) begin
            valid_next = 1'b1;
            hyph_next  = slot.hyph;
            slot_next  = slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hyph_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hyph_reg  <= hyph_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    // a pending hyphen always belongs to a held byte
    `VCSS_ASSERT_IMP(a_hyph_has_slot, aclk, aresetn, hyph_reg, valid_reg)
    // a hyphen word sent is followed by its byte word
    `VCSS_ASSERT_NXT(a_hyph_then_byte, aclk, aresetn, m_tvalid && m_tready && hyph_reg, m_tvalid && !hyph_reg)
    // a new slot only lands when the register can take it
    `VCSS_ASSERT_IMP(a_load_when_free, aclk, aresetn, slot_load, slot_free)

endmodule
